@@ rtl/awt_pkg.sv @@
`timescale 1ns / 1ps

package awt_pkg;

    localparam int unsigned SLOT_COUNT_DEF  = 256;
    localparam int unsigned INDEX_SHIFT_DEF = 4;
    localparam int unsigned ADDR_W          = 64;
    localparam int unsigned CNT_W           = 64;
    localparam int unsigned QUEUE_DEPTH     = 2;

    // action codes on the command port
    typedef enum logic [2:0] {
        ACT_WATCH = 3'd0,
        ACT_TRACE = 3'd1,
        ACT_COPY  = 3'd2,
        ACT_CRASH = 3'd3,
        ACT_READ  = 3'd4
    } t_action;

    // operation after classification by the front end
    typedef enum logic [2:0] {
        OP_IGNORE = 3'd0,
        OP_WATCH  = 3'd1,
        OP_TRACE  = 3'd2,
        OP_COPY   = 3'd3,
        OP_CRASH  = 3'd4,
        OP_READ   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_HIT    = 2'd1,
        KIND_SLOT   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_APPLIED   = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_COLLISION = 3'd2,
        ST_NO_MATCH  = 3'd3,
        ST_IGNORED   = 3'd4
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [ADDR_W-1:0]  addr;
        logic [ADDR_W-1:0]  second_addr;
        logic [7:0]         slot_index;
        logic               addr_nz;
        logic               second_nz;
    } t_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0] owner;
        logic [CNT_W-1:0]  traced;
        logic [CNT_W-1:0]  moved;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

endpackage

@@ rtl/awt_ram.sv @@
`timescale 1ns / 1ps

module awt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/awt_cmd_queue.sv @@
`timescale 1ns / 1ps

module awt_cmd_queue
    import awt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_head
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_QW-1:0] r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_full  = (r_count == CNT_QW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

endmodule

@@ rtl/awt_front.sv @@
`timescale 1ns / 1ps

module awt_front
    import awt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_start,
    input  logic [2:0]        i_action,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [ADDR_W-1:0] i_second_addr,
    input  logic [7:0]        i_slot_index,
    input  logic              i_clearing,
    input  logic              i_q_full,
    output logic              o_busy,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic r_enable;
    logic a_nz;
    logic b_nz;
    t_op  op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_wdata;
        end
    end

    assign a_nz = (i_addr != '0);
    assign b_nz = (i_second_addr != '0);

    // trace is the one action that runs with diagnostics off
    always_comb begin
        case (t_action'(i_action))
            ACT_WATCH: op = (r_enable && a_nz) ? OP_WATCH : OP_IGNORE;
            ACT_TRACE: op = a_nz ? OP_TRACE : OP_IGNORE;
            ACT_COPY:  op = (r_enable && a_nz && b_nz) ? OP_COPY : OP_IGNORE;
            ACT_CRASH: op = r_enable ? OP_CRASH : OP_IGNORE;
            ACT_READ:  op = r_enable ? OP_READ : OP_IGNORE;
            default:   op = OP_IGNORE;
        endcase
    end

    assign o_busy = i_q_full || i_clearing;
    assign o_push = i_start && !o_busy;

    always_comb begin
        o_cmd.op          = op;
        o_cmd.addr        = i_addr;
        o_cmd.second_addr = i_second_addr;
        o_cmd.slot_index  = i_slot_index;
        o_cmd.addr_nz     = a_nz;
        o_cmd.second_nz   = b_nz;
    end

endmodule

@@ rtl/awt_back.sv @@
`timescale 1ns / 1ps

module awt_back
    import awt_pkg::*;
#(
    parameter int unsigned SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int unsigned INDEX_SHIFT = INDEX_SHIFT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_cmd              i_q_head,
    output logic              o_q_pop,
    output logic              o_clearing,
    output logic              o_strobe,
    output logic [1:0]        o_kind,
    output logic [2:0]        o_status,
    output logic [ADDR_W-1:0] o_holder_addr,
    output logic [CNT_W-1:0]  o_traced_count,
    output logic [CNT_W-1:0]  o_moved_count,
    output logic              o_followed,
    output logic [CNT_W-1:0]  o_watched_total,
    output logic [CNT_W-1:0]  o_collision_total,
    output logic [CNT_W-1:0]  o_crash_hit_total,
    output logic              o_last
);

    localparam int unsigned SLOT_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned IDX_W     = (SLOT_BITS > 8) ? SLOT_BITS : 8;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SLOT_A = 5'b00100,
        S_SLOT_B = 5'b01000,
        S_EMIT_B = 5'b10000
    } t_state;

    function automatic logic [SLOT_BITS-1:0] slot_of(input logic [ADDR_W-1:0] a);
        return a[INDEX_SHIFT +: SLOT_BITS];
    endfunction

    t_state                r_state, n_state;
    logic [SLOT_BITS-1:0]  r_clr_addr, n_clr_addr;
    t_cmd                  r_cmd, n_cmd;
    t_entry                r_ent_a, n_ent_a;
    logic                  r_hit_a, n_hit_a;
    t_entry                r_ent_b, n_ent_b;
    logic [CNT_W-1:0]      r_watched, n_watched;
    logic [CNT_W-1:0]      r_collision, n_collision;
    logic [CNT_W-1:0]      r_crash_hit, n_crash_hit;

    logic                  r_strobe;
    t_kind                 r_kind;
    t_status               r_status;
    t_entry                r_out_ent;
    logic                  r_last;

    logic                  emit;
    t_kind                 e_kind;
    t_status               e_status;
    t_entry                e_ent;
    logic                  e_last;

    logic                  ram_we;
    logic [SLOT_BITS-1:0]  ram_waddr;
    t_entry                ram_wdata;
    logic [SLOT_BITS-1:0]  ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;
    t_entry                ent;

    logic [IDX_W-1:0]      head_idx;
    logic [SLOT_BITS-1:0]  head_slot;
    logic                  hit_b;

    awt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ent       = t_entry'(ram_rdata);
    assign head_idx  = IDX_W'(i_q_head.slot_index);
    assign head_slot = (i_q_head.op == OP_READ) ? head_idx[SLOT_BITS-1:0]
                                                : slot_of(i_q_head.addr);

    // first slot is read as the command leaves the queue, the second one in the cycle after
    assign ram_raddr = (r_state == S_IDLE) ? head_slot : slot_of(r_cmd.second_addr);
    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid;
    assign hit_b     = r_cmd.second_nz && (ent.owner == r_cmd.second_addr);

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_cmd       = r_cmd;
        n_ent_a     = r_ent_a;
        n_hit_a     = r_hit_a;
        n_ent_b     = r_ent_b;
        n_watched   = r_watched;
        n_collision = r_collision;
        n_crash_hit = r_crash_hit;
        emit        = 1'b0;
        e_kind      = KIND_STATUS;
        e_status    = ST_APPLIED;
        e_ent       = '0;
        e_last      = 1'b1;
        ram_we      = 1'b0;
        ram_waddr   = slot_of(r_cmd.addr);
        ram_wdata   = '0;

        case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == SLOT_BITS'(SLOT_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    n_cmd   = i_q_head;
                    n_state = S_SLOT_A;
                end
            end
            S_SLOT_A: begin
                n_state = S_IDLE;
                case (r_cmd.op)
                    OP_WATCH: begin
                        emit = 1'b1;
                        if (ent.owner == r_cmd.addr) begin
                            e_status = ST_PRESENT;
                        end else if (ent.owner != '0) begin
                            e_status    = ST_COLLISION;
                            n_collision = r_collision + 1'b1;
                        end else begin
                            ram_we          = 1'b1;
                            ram_wdata.owner = r_cmd.addr;
                            n_watched       = r_watched + 1'b1;
                        end
                    end
                    OP_TRACE: begin
                        emit = 1'b1;
                        if (ent.owner == r_cmd.addr) begin
                            ram_we           = 1'b1;
                            ram_wdata        = ent;
                            ram_wdata.traced = ent.traced + 1'b1;
                        end else begin
                            e_status = ST_NO_MATCH;
                        end
                    end
                    OP_COPY: begin
                        if (ent.owner == r_cmd.addr) begin
                            ram_we          = 1'b1;
                            ram_wdata       = ent;
                            ram_wdata.moved = ent.moved + 1'b1;
                            n_state         = S_SLOT_B;
                        end else begin
                            emit     = 1'b1;
                            e_status = ST_NO_MATCH;
                        end
                    end
                    OP_CRASH: begin
                        n_ent_a = ent;
                        n_hit_a = r_cmd.addr_nz && (ent.owner == r_cmd.addr);
                        n_state = S_SLOT_B;
                    end
                    OP_READ: begin
                        emit   = 1'b1;
                        e_kind = KIND_SLOT;
                        e_ent  = ent;
                    end
                    default: begin
                        emit     = 1'b1;
                        e_status = ST_IGNORED;
                    end
                endcase
            end
            S_SLOT_B: begin
                n_state = S_IDLE;
                emit    = 1'b1;
                if (r_cmd.op == OP_COPY) begin
                    // a destination that holds anything, even the source, collides
                    if (ent.owner == '0) begin
                        ram_we          = 1'b1;
                        ram_waddr       = slot_of(r_cmd.second_addr);
                        ram_wdata.owner = r_cmd.second_addr;
                    end else begin
                        e_status    = ST_COLLISION;
                        n_collision = r_collision + 1'b1;
                    end
                end else begin
                    n_ent_b = ent;
                    if (r_hit_a) begin
                        e_kind      = KIND_HIT;
                        e_ent       = r_ent_a;
                        e_last      = !hit_b;
                        n_crash_hit = r_crash_hit + 1'b1;
                        if (hit_b) begin
                            n_state = S_EMIT_B;
                        end
                    end else if (hit_b) begin
                        e_kind      = KIND_HIT;
                        e_ent       = ent;
                        n_crash_hit = r_crash_hit + 1'b1;
                    end else begin
                        e_status = ST_NO_MATCH;
                    end
                end
            end
            S_EMIT_B: begin
                emit        = 1'b1;
                e_kind      = KIND_HIT;
                e_ent       = r_ent_b;
                n_crash_hit = r_crash_hit + 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_watched   <= '0;
            r_collision <= '0;
            r_crash_hit <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_watched   <= n_watched;
            r_collision <= n_collision;
            r_crash_hit <= n_crash_hit;
            r_strobe    <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_ent_a <= n_ent_a;
        r_hit_a <= n_hit_a;
        r_ent_b <= n_ent_b;
        if (emit) begin
            r_kind    <= e_kind;
            r_status  <= e_status;
            r_out_ent <= e_ent;
            r_last    <= e_last;
        end
    end

    assign o_clearing        = (r_state == S_CLEAR);
    assign o_strobe          = r_strobe;
    assign o_kind            = r_kind;
    assign o_status          = r_status;
    assign o_holder_addr     = r_out_ent.owner;
    assign o_traced_count    = r_out_ent.traced;
    assign o_moved_count     = r_out_ent.moved;
    assign o_followed        = (r_out_ent.traced != '0);
    // totals only move at edges that also load a result, so they match it
    assign o_watched_total   = r_watched;
    assign o_collision_total = r_collision;
    assign o_crash_hit_total = r_crash_hit;
    assign o_last            = r_last;

endmodule

@@ rtl/address_watch_table_top.sv @@
`timescale 1ns / 1ps

// channel     | direction | handshake                     | payload
// ------------+-----------+-------------------------------+----------------------------------
// command     | in        | start, busy                   | i_action, i_addr, i_second_addr,
//             |           |                               | i_slot_index
// result      | out       | o_strobe (one cycle, no stall) | o_kind .. o_crash_hit_total, o_last
// config      | in        | i_cfg_we                      | i_cfg_wdata (enable)
//
// a command is taken when start is high and busy is low and waits in a two-entry queue;
// busy is high while that queue is full. the back end takes each command through S_IDLE
// and S_SLOT_A, a matching copy and an enabled crash-join also through S_SLOT_B, and a
// crash-join with two hits also through S_EMIT_B. results cannot be held off. after reset
// busy stays high while all SLOT_COUNT RAM slots are zeroed. SLOT_COUNT must be a power
// of two, which the block does not check; the slot is (addr >> INDEX_SHIFT) % SLOT_COUNT.

module address_watch_table_top
    import awt_pkg::*;
#(
    parameter int unsigned SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int unsigned INDEX_SHIFT = INDEX_SHIFT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_action,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [ADDR_W-1:0] i_second_addr,
    input  logic [7:0]        i_slot_index,
    output logic              o_strobe,
    output logic [1:0]        o_kind,
    output logic [2:0]        o_status,
    output logic [ADDR_W-1:0] o_holder_addr,
    output logic [CNT_W-1:0]  o_traced_count,
    output logic [CNT_W-1:0]  o_moved_count,
    output logic              o_followed,
    output logic [CNT_W-1:0]  o_watched_total,
    output logic [CNT_W-1:0]  o_collision_total,
    output logic [CNT_W-1:0]  o_crash_hit_total,
    output logic              o_last
);

    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_cmd q_head;
    logic clearing;

    awt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_start       (start),
        .i_action      (i_action),
        .i_addr        (i_addr),
        .i_second_addr (i_second_addr),
        .i_slot_index  (i_slot_index),
        .i_clearing    (clearing),
        .i_q_full      (q_full),
        .o_busy        (busy),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    awt_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    awt_back #(
        .SLOT_COUNT  (SLOT_COUNT),
        .INDEX_SHIFT (INDEX_SHIFT)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_head          (q_head),
        .o_q_pop           (q_pop),
        .o_clearing        (clearing),
        .o_strobe          (o_strobe),
        .o_kind            (o_kind),
        .o_status          (o_status),
        .o_holder_addr     (o_holder_addr),
        .o_traced_count    (o_traced_count),
        .o_moved_count     (o_moved_count),
        .o_followed        (o_followed),
        .o_watched_total   (o_watched_total),
        .o_collision_total (o_collision_total),
        .o_crash_hit_total (o_crash_hit_total),
        .o_last            (o_last)
    );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import awt_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;
    // action codes the block does not define; they must come back as ignored
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    localparam logic [ADDR_W-1:0] ADDR_A     = 64'h0000_0000_0000_1230;
    localparam logic [ADDR_W-1:0] ADDR_A_ALT = 64'h8000_0000_0000_1230;
    localparam logic [ADDR_W-1:0] ADDR_B     = 64'h0000_0000_0000_4560;
    localparam logic [ADDR_W-1:0] ADDR_C     = 64'h0000_0000_0000_7890;
    localparam logic [ADDR_W-1:0] ADDR_D     = 64'h0000_0000_0000_9990;
    localparam logic [ADDR_W-1:0] ADDR_ONE   = 64'h0000_0000_0000_0001;
    localparam logic [ADDR_W-1:0] ADDR_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [ADDR_W-1:0] SLOT_FIELD =
        64'(SLOT_COUNT_DEF - 1) << INDEX_SHIFT_DEF;

    typedef struct {
        logic [1:0]        kind;
        logic [2:0]        status;
        logic [ADDR_W-1:0] holder;
        logic [CNT_W-1:0]  traced;
        logic [CNT_W-1:0]  moved;
        logic              followed;
        logic [CNT_W-1:0]  watched;
        logic [CNT_W-1:0]  collisions;
        logic [CNT_W-1:0]  crash_hits;
        logic              last;
    } t_watch_result;

    function automatic logic [7:0] slot_of(input logic [ADDR_W-1:0] a);
        return 8'((a >> INDEX_SHIFT_DEF) % SLOT_COUNT_DEF);
    endfunction

    class watch_table_scoreboard;
        logic [ADDR_W-1:0] held_addr [SLOT_COUNT_DEF];
        logic [CNT_W-1:0]  trace_cnt [SLOT_COUNT_DEF];
        logic [CNT_W-1:0]  move_cnt  [SLOT_COUNT_DEF];
        logic [CNT_W-1:0]  claims;
        logic [CNT_W-1:0]  collisions;
        logic [CNT_W-1:0]  crash_hits;
        logic              enabled;
        t_watch_result     expected_results [$];
        int unsigned       errors;
        int unsigned       n_cmds;
        int unsigned       n_results;

        function new();
            foreach (held_addr[i]) begin
                held_addr[i] = '0;
                trace_cnt[i] = '0;
                move_cnt[i]  = '0;
            end
            claims     = '0;
            collisions = '0;
            crash_hits = '0;
            enabled    = 1'b0;
            errors     = 0;
            n_cmds     = 0;
            n_results  = 0;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function void claim(input logic [7:0] s, input logic [ADDR_W-1:0] a);
            held_addr[s] = a;
            trace_cnt[s] = '0;
            move_cnt[s]  = '0;
        endfunction

        function void add_result(input t_kind kind, input t_status st,
                                 input logic show_slot, input logic [7:0] s,
                                 input logic last);
            t_watch_result r;
            r.kind       = kind;
            r.status     = st;
            r.holder     = show_slot ? held_addr[s] : '0;
            r.traced     = show_slot ? trace_cnt[s] : '0;
            r.moved      = show_slot ? move_cnt[s] : '0;
            r.followed   = show_slot && (trace_cnt[s] != 0);
            r.watched    = claims;
            r.collisions = collisions;
            r.crash_hits = crash_hits;
            r.last       = last;
            expected_results.push_back(r);
        endfunction

        // apply one accepted transaction to the table copy and queue its results
        function void note_cmd(input logic [2:0] act, input logic [ADDR_W-1:0] a,
                               input logic [ADDR_W-1:0] b, input logic [7:0] idx);
            logic [7:0] s;
            logic [7:0] d;
            logic       hit_a;
            logic       hit_b;
            t_status    st;
            s     = slot_of(a);
            d     = slot_of(b);
            st    = ST_IGNORED;
            n_cmds++;
            case (act)
                ACT_WATCH: begin
                    if (enabled && a != 0) begin
                        if (held_addr[s] == a) begin
                            st = ST_PRESENT;
                        end else if (held_addr[s] != 0) begin
                            collisions++;
                            st = ST_COLLISION;
                        end else begin
                            claim(s, a);
                            claims++;
                            st = ST_APPLIED;
                        end
                    end
                    add_result(KIND_STATUS, st, 1'b0, s, 1'b1);
                end
                ACT_TRACE: begin
                    if (a != 0) begin
                        if (held_addr[s] == a) begin
                            trace_cnt[s]++;
                            st = ST_APPLIED;
                        end else begin
                            st = ST_NO_MATCH;
                        end
                    end
                    add_result(KIND_STATUS, st, 1'b0, s, 1'b1);
                end
                ACT_COPY: begin
                    if (enabled && a != 0 && b != 0) begin
                        if (held_addr[s] != a) begin
                            st = ST_NO_MATCH;
                        end else begin
                            move_cnt[s]++;
                            // destination counts as taken even when it holds b or a
                            if (held_addr[d] == 0) begin
                                claim(d, b);
                                st = ST_APPLIED;
                            end else begin
                                collisions++;
                                st = ST_COLLISION;
                            end
                        end
                    end
                    add_result(KIND_STATUS, st, 1'b0, s, 1'b1);
                end
                ACT_CRASH: begin
                    if (!enabled) begin
                        add_result(KIND_STATUS, ST_IGNORED, 1'b0, s, 1'b1);
                    end else begin
                        hit_a = (a != 0) && (held_addr[s] == a);
                        hit_b = (b != 0) && (held_addr[d] == b);
                        if (hit_a) begin
                            crash_hits++;
                            add_result(KIND_HIT, ST_APPLIED, 1'b1, s, !hit_b);
                        end
                        if (hit_b) begin
                            crash_hits++;
                            add_result(KIND_HIT, ST_APPLIED, 1'b1, d, 1'b1);
                        end
                        if (!hit_a && !hit_b) begin
                            add_result(KIND_STATUS, ST_NO_MATCH, 1'b0, s, 1'b1);
                        end
                    end
                end
                ACT_READ: begin
                    if (enabled) begin
                        add_result(KIND_SLOT, ST_APPLIED, 1'b1,
                                   8'(idx % SLOT_COUNT_DEF), 1'b1);
                    end else begin
                        add_result(KIND_STATUS, ST_IGNORED, 1'b0, s, 1'b1);
                    end
                end
                default: begin
                    add_result(KIND_STATUS, ST_IGNORED, 1'b0, s, 1'b1);
                end
            endcase
        endfunction

        function void check_field(input string name, input logic [63:0] want,
                                  input logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(input t_watch_result got);
            t_watch_result want;
            n_results++;
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing expected (kind %0d, status %0d)",
                       got.kind, got.status);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            check_field("kind", 64'(want.kind), 64'(got.kind));
            check_field("status", 64'(want.status), 64'(got.status));
            check_field("holder_addr", want.holder, got.holder);
            check_field("traced_count", want.traced, got.traced);
            check_field("moved_count", want.moved, got.moved);
            check_field("followed", 64'(want.followed), 64'(got.followed));
            check_field("watched_total", want.watched, got.watched);
            check_field("collision_total", want.collisions, got.collisions);
            check_field("crash_hit_total", want.crash_hits, got.crash_hits);
            check_field("last", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_wdata;
    logic              start;
    logic              busy;
    logic [2:0]        i_action;
    logic [ADDR_W-1:0] i_addr;
    logic [ADDR_W-1:0] i_second_addr;
    logic [7:0]        i_slot_index;
    logic              o_strobe;
    logic [1:0]        o_kind;
    logic [2:0]        o_status;
    logic [ADDR_W-1:0] o_holder_addr;
    logic [CNT_W-1:0]  o_traced_count;
    logic [CNT_W-1:0]  o_moved_count;
    logic              o_followed;
    logic [CNT_W-1:0]  o_watched_total;
    logic [CNT_W-1:0]  o_collision_total;
    logic [CNT_W-1:0]  o_crash_hit_total;
    logic              o_last;

    watch_table_scoreboard sb;
    logic [ADDR_W-1:0]     addr_pool [$];
    int unsigned           cycle_count = 0;

    always #1 i_clk = ~i_clk;

    address_watch_table_top u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .start             (start),
        .busy              (busy),
        .i_action          (i_action),
        .i_addr            (i_addr),
        .i_second_addr     (i_second_addr),
        .i_slot_index      (i_slot_index),
        .o_strobe          (o_strobe),
        .o_kind            (o_kind),
        .o_status          (o_status),
        .o_holder_addr     (o_holder_addr),
        .o_traced_count    (o_traced_count),
        .o_moved_count     (o_moved_count),
        .o_followed        (o_followed),
        .o_watched_total   (o_watched_total),
        .o_collision_total (o_collision_total),
        .o_crash_hit_total (o_crash_hit_total),
        .o_last            (o_last)
    );

    always @(posedge i_clk) begin
        t_watch_result got;
        if (i_rst_n && o_strobe) begin
            got.kind       = o_kind;
            got.status     = o_status;
            got.holder     = o_holder_addr;
            got.traced     = o_traced_count;
            got.moved      = o_moved_count;
            got.followed   = o_followed;
            got.watched    = o_watched_total;
            got.collisions = o_collision_total;
            got.crash_hits = o_crash_hit_total;
            got.last       = o_last;
            sb.check_result(got);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic issue(input logic [2:0] act, input logic [ADDR_W-1:0] a,
                         input logic [ADDR_W-1:0] b, input logic [7:0] idx);
        @(negedge i_clk);
        start         <= 1'b1;
        i_action      <= act;
        i_addr        <= a;
        i_second_addr <= b;
        i_slot_index  <= idx;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_cmd(act, a, b, idx);
    endtask

    task automatic hold_off(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_enable(input logic value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.enabled = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly addresses already seen or sharing a slot with one, so the table fills
    // and hits, collisions and moves are common
    function automatic logic [ADDR_W-1:0] pick_addr();
        int unsigned       r;
        logic [ADDR_W-1:0] a;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (addr_pool.size() == 0 || r >= 78) begin
            a = {$urandom, $urandom};
            if (a == 0) a = ADDR_ONE;
            if (addr_pool.size() < 48) addr_pool.push_back(a);
            else addr_pool[$urandom_range(0, addr_pool.size() - 1)] = a;
        end else begin
            a = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
            if (r >= 58) begin
                a = a ^ ({$urandom, $urandom} & ~SLOT_FIELD);
                if (a == 0) a = ADDR_ONE << INDEX_SHIFT_DEF;
            end
        end
        return a;
    endfunction

    task automatic random_items(input int unsigned count, input int unsigned idle_pct);
        int unsigned       r;
        logic [2:0]        act;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic [7:0]        idx;
        for (int unsigned i = 0; i < count; i++) begin
            // each sender cycle idles with the given chance
            while ($urandom_range(0, 99) < idle_pct) hold_off(1);
            r = $urandom_range(0, 99);
            if (r < 25) act = ACT_WATCH;
            else if (r < 50) act = ACT_TRACE;
            else if (r < 68) act = ACT_COPY;
            else if (r < 83) act = ACT_CRASH;
            else if (r < 95) act = ACT_READ;
            else act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
            a = pick_addr();
            b = (act == ACT_COPY || act == ACT_CRASH) ? pick_addr()
                                                      : {$urandom, $urandom};
            idx = 8'($urandom);
            if (act == ACT_READ && addr_pool.size() != 0 && $urandom_range(0, 1) == 1) begin
                idx = slot_of(addr_pool[$urandom_range(0, addr_pool.size() - 1)]);
            end
            issue(act, a, b, idx);
        end
    endtask

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        start         = 1'b0;
        i_action      = ACT_WATCH;
        i_addr        = '0;
        i_second_addr = '0;
        i_slot_index  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_enable(1'b0);

        // disabled: only trace does anything
        issue(ACT_WATCH, ADDR_A, ADDR_B, 8'h00);
        issue(ACT_TRACE, ADDR_A, ADDR_B, 8'h00);
        issue(ACT_COPY, ADDR_A, ADDR_B, 8'h00);
        issue(ACT_CRASH, ADDR_A, ADDR_B, 8'h00);
        issue(ACT_READ, ADDR_A, ADDR_B, 8'hFF);
        issue(ACT_SPARE_HI, ADDR_A, ADDR_B, 8'hFF);
        wait_idle();
        write_enable(1'b1);

        issue(ACT_WATCH, '0, ADDR_ONES, 8'hFF);
        issue(ACT_WATCH, ADDR_A, '0, 8'h00);
        issue(ACT_WATCH, ADDR_A, '0, 8'h00);
        issue(ACT_WATCH, ADDR_A_ALT, '0, 8'h00);
        issue(ACT_TRACE, ADDR_A, '0, 8'h00);
        issue(ACT_TRACE, ADDR_A_ALT, '0, 8'h00);
        issue(ACT_TRACE, '0, ADDR_ONES, 8'h00);
        issue(ACT_WATCH, ADDR_ONES, ADDR_ONES, 8'hFF);
        issue(ACT_TRACE, ADDR_ONES, ADDR_ONES, 8'hFF);
        issue(ACT_WATCH, ADDR_ONE, '0, 8'h00);
        issue(ACT_COPY, ADDR_A, ADDR_B, 8'h00);
        issue(ACT_COPY, ADDR_A, ADDR_B, 8'h00);
        issue(ACT_COPY, ADDR_A, ADDR_A, 8'h00);
        issue(ACT_COPY, ADDR_C, ADDR_D, 8'h00);
        issue(ACT_COPY, ADDR_A, '0, 8'h00);
        issue(ACT_COPY, '0, ADDR_B, 8'h00);
        issue(ACT_CRASH, ADDR_A, ADDR_B, 8'h00);
        issue(ACT_CRASH, ADDR_A, '0, 8'h00);
        issue(ACT_CRASH, '0, ADDR_B, 8'h00);
        issue(ACT_CRASH, ADDR_A_ALT, ADDR_D, 8'h00);
        issue(ACT_CRASH, '0, '0, 8'h00);
        issue(ACT_READ, '0, '0, 8'h00);
        issue(ACT_READ, ADDR_ONES, ADDR_ONES, 8'hFF);
        issue(ACT_READ, '0, '0, slot_of(ADDR_A));
        issue(ACT_SPARE_LO, ADDR_A, ADDR_B, slot_of(ADDR_A));
        issue(ACT_SPARE_LO + 3'd1, ADDR_A, ADDR_B, slot_of(ADDR_A));

        random_items(400, 23);
        wait_idle();
        write_enable(1'b0);
        random_items(100, 23);
        wait_idle();
        write_enable(1'b1);
        random_items(320, 70);
        random_items(400, 0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d commands over both enable settings, %0d results checked",
                 sb.n_cmds, sb.n_results);
        $display("table totals: %0d claims, %0d collisions, %0d crash-join hits",
                 sb.claims, sb.collisions, sb.crash_hits);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
